// ----- rtl/vsio_pkg.sv -----
// shared types and codes for the voice/staff interval overlap core
`default_nettype none

package vsio_pkg;

  localparam int unsigned TickW  = 31;
  localparam int unsigned VoiceW = 4;
  localparam int unsigned StaffW = 3;
  localparam int unsigned CmdW   = 2;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  // note probe travelling down the cell chain
  typedef struct packed {
    logic              valid;
    logic              stored;
    logic              hit;
    logic [TickW-1:0]  start_tick;
    logic [TickW-1:0]  end_tick;
    logic [VoiceW-1:0] voice;
    logic [StaffW-1:0] staff;
  } probe_t;

endpackage

`default_nettype wire

// ----- rtl/vsio_cell.sv -----
// one table slot: holds a note, checks a passing probe, takes it if empty
`default_nettype none

module vsio_cell import vsio_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   clear_i,
  input  wire probe_t probe_i,
  output probe_t      probe_o
);

  logic                      vld_q, vld_d;
  logic [TickW-1:0]          start_q, end_q;
  logic [VoiceW-1:0]         voice_q;
  logic [StaffW-1:0]         staff_q;
  logic                      take;
  logic                      match;
  probe_t                    probe_d;
  logic                      pvld_q;
  logic [$bits(probe_t)-2:0] pay_q;

  // overlap of half-open intervals, same voice, different staff
  assign match = (voice_q == probe_i.voice) && (staff_q != probe_i.staff) &&
                 (start_q < probe_i.end_tick) && (probe_i.start_tick < end_q);

  assign take = probe_i.valid && !probe_i.stored && !vld_q;

  // next probe and slot valid
  always_comb begin
    probe_d = probe_i;
    vld_d   = vld_q;
    if (take) begin
      probe_d.stored = 1'b1;
      vld_d          = 1'b1;
    end else if (probe_i.valid && !probe_i.stored && vld_q && match) begin
      probe_d.hit = 1'b1;
    end
    if (clear_i) begin
      vld_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      pvld_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      pvld_q <= probe_d.valid;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pay_q <= probe_d[$bits(probe_t)-2:0];
    if (take) begin
      start_q <= probe_i.start_tick;
      end_q   <= probe_i.end_tick;
      voice_q <= probe_i.voice;
      staff_q <= probe_i.staff;
    end
  end

  assign probe_o = {pvld_q, pay_q};

endmodule

`default_nettype wire

// ----- rtl/voice_staff_interval_overlap_core.sv -----
// top level: command decode, note cell chain and per-voice overlap flags
//
// channel  | direction | ports                                        | handshake
// command  | in        | cmd_i start_tick_i end_tick_i voice_i staff_i | start_i & !busy_o
// result   | out       | overlap_o status_o                           | done_o, one cycle
//
// an add that is stored or dropped for a full table holds busy_o high while the note
// walks the chain of cells, and its result shows on done_o in the first cycle with busy_o low
// clear, query, unused commands and ignored adds leave busy_o low
// and show their result on done_o the cycle after accept
// reset empties every cell and clears all voice flags at once
// the receiver cannot stall; busy_o is the only back-pressure
`default_nettype none

module voice_staff_interval_overlap_core import vsio_pkg::*; #(
  parameter int unsigned NUM_STAVES = 4,
  parameter int unsigned MAX_NOTES  = 64,
  parameter int unsigned NUM_VOICES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [CmdW-1:0]   cmd_i,
  input  wire logic [TickW-1:0]  start_tick_i,
  input  wire logic [TickW-1:0]  end_tick_i,
  input  wire logic [VoiceW-1:0] voice_i,
  input  wire logic [StaffW-1:0] staff_i,
  output logic                   done_o,
  output logic                   overlap_o,
  output logic [1:0]             status_o
);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_e;

  state_e              state_q;
  logic                accept;
  logic                staff_ok, voice_ok;
  logic                clear;
  logic                flag_rd;
  logic [NUM_VOICES-1:0] flag_q, flag_d;
  logic                done_q;
  logic                overlap_q;
  status_e             status_q;
  logic                inj_vld_q;
  logic [$bits(probe_t)-2:0] inj_pay_q;
  probe_t              chain [MAX_NOTES+1];
  probe_t              tail;

  assign accept   = start_i && (state_q == S_IDLE);
  assign staff_ok = 32'(staff_i) < NUM_STAVES;
  assign voice_ok = 32'(voice_i) < NUM_VOICES;
  assign clear    = accept && (cmd_e'(cmd_i) == CMD_CLEAR);
  assign tail     = chain[MAX_NOTES];

  // flag lookup for a query
  always_comb begin
    flag_rd = 1'b0;
    for (int i = 0; i < int'(NUM_VOICES); i++) begin
      if (32'(voice_i) == i) begin
        flag_rd = flag_q[i];
      end
    end
  end

  // flag update: sticky set at end of a stored add, clear on new measure
  always_comb begin
    flag_d = flag_q;
    if (tail.valid && tail.stored && tail.hit) begin
      for (int i = 0; i < int'(NUM_VOICES); i++) begin
        if (32'(tail.voice) == i) begin
          flag_d[i] = 1'b1;
        end
      end
    end
    if (clear) begin
      flag_d = '0;
    end
  end

  // cell chain
  assign chain[0] = {inj_vld_q, inj_pay_q};
  for (genvar g = 0; g < MAX_NOTES; g++) begin : g_cell
    vsio_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear),
      .probe_i (chain[g]),
      .probe_o (chain[g+1])
    );
  end

  // probe payload: not stored, no hit yet
  always_ff @(posedge clk_i) begin
    inj_pay_q <= {1'b0, 1'b0, start_tick_i, end_tick_i, voice_i, staff_i};
  end

  // control state, flags and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      inj_vld_q <= 1'b0;
      flag_q    <= '0;
      done_q    <= 1'b0;
      overlap_q <= 1'b0;
      status_q  <= ST_DONE;
    end else begin
      flag_q    <= flag_d;
      inj_vld_q <= 1'b0;
      done_q    <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            overlap_q <= 1'b0;
            status_q  <= ST_DONE;
            unique case (cmd_e'(cmd_i))
              CMD_ADD: begin
                if (staff_ok && voice_ok) begin
                  inj_vld_q <= 1'b1;
                  state_q   <= S_BUSY;
                end else begin
                  status_q <= ST_IGNORED;
                  done_q   <= 1'b1;
                end
              end
              CMD_QUERY: begin
                overlap_q <= voice_ok && flag_rd;
                done_q    <= 1'b1;
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_BUSY: begin
          if (tail.valid) begin
            state_q   <= S_IDLE;
            done_q    <= 1'b1;
            overlap_q <= 1'b0;
            status_q  <= tail.stored ? ST_DONE : ST_FULL;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o    = (state_q == S_BUSY);
  assign done_o    = done_q;
  assign overlap_o = overlap_q;
  assign status_o  = status_q;

  // a result never shows while an add is in the chain
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");

  // the chain only delivers a probe while an add is pending
  a_tail_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> busy_o) else $error("probe left chain while idle");

  // an in-range add always enters the chain
  a_add_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_e'(cmd_i) == CMD_ADD) && staff_ok && voice_ok) |=> busy_o)
    else $error("add did not start the chain");

  // a dropped or stored add never reports an overlap bit
  a_add_no_ovl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && tail.valid) |=> (done_o && !overlap_o))
    else $error("add result malformed");

endmodule

`default_nettype wire
